// ===== rtl/core/osbf_pkg.sv =====
// Shared types and constants for the orthographic shadow bounds fit block.
`default_nettype none
package osbf_pkg;

   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 4;
   localparam int OUT_W      = 31;
   localparam int TOL_W      = 16;
   localparam int TOL_SHIFT  = 16;
   localparam int FRAC_BITS  = 16;
   localparam int UNIT_SHIFT = 30;
   localparam int ROOT_W     = 32;
   localparam int RAD_W      = 64;
   localparam int MUL_W      = 32;
   localparam int CMP_W      = OUT_W + TOL_SHIFT + 1;

   localparam logic [OUT_W-1:0] MIN_NEAR_RESET   = 31'd3277;
   localparam logic [OUT_W-1:0] MIN_RADIUS_RESET = 31'd66;
   localparam logic [TOL_W-1:0] TOL_RESET        = 16'd7;
   localparam logic [OUT_W-1:0] UNIT_ONE         = OUT_W'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      REG_MIN_NEAR   = 2'd0,
      REG_MIN_RADIUS = 2'd1,
      REG_CHANGE_TOL = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_ON_TARGET = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_NORM,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_ROOT,
      ST_DIV_GO,
      ST_DIV,
      ST_MU_LO,
      ST_MU_HI,
      ST_MU_FIN,
      ST_NEAR,
      ST_FAR,
      ST_TOL_MUL,
      ST_TOL_CMP,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_RADIUS,
      PH_DIR,
      PH_ALONG,
      PH_AM,
      PH_ACROSS
   } phase_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } sq_cmd_type;

endpackage
`default_nettype wire

// ===== rtl/core/osbf_sqdiv.sv =====
// Shared iterative unit: 64-bit floor square root or 61-by-32 bit divide, one bit a cycle.
`default_nettype none
module osbf_sqdiv (
   input  logic                          clock,
   input  logic                          reset,
   input  osbf_pkg::sq_cmd_type          cmd,
   input  logic [osbf_pkg::RAD_W-1:0]    operand,
   input  logic [osbf_pkg::ROOT_W-1:0]   divisor,
   output logic                          done,
   output logic [osbf_pkg::ROOT_W-1:0]   result
);
   import osbf_pkg::*;

   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               div_ff, div_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RAD_W-1:0]   data_ff, data_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  res_ff, res_in;
   logic [ROOT_W-1:0]  dvs_ff, dvs_in;

   logic [REM_W-1:0]   x_val;
   logic [REM_W-1:0]   y_val;
   logic [REM_W-1:0]   d_val;
   logic               ge;

   // Square root brings down two radicand bits per step, division one.
   assign x_val = div_ff ? {rem_ff[REM_W-2:0], data_ff[RAD_W-1]}
                         : {rem_ff[REM_W-3:0], data_ff[RAD_W-1:RAD_W-2]};
   assign y_val = div_ff ? REM_W'(dvs_ff) : {1'b0, res_ff, 2'b01};
   assign ge    = x_val >= y_val;
   assign d_val = x_val - y_val;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      data_in = data_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      dvs_in  = dvs_ff;
      if (busy_ff) begin
         rem_in  = ge ? d_val : x_val;
         res_in  = {res_ff[ROOT_W-2:0], ge};
         data_in = div_ff ? (data_ff << 1) : (data_ff << 2);
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.is_div;
         dvs_in  = divisor;
         res_in  = '0;
         if (cmd.is_div) begin
            // The quotient fits 31 bits, so the top part starts below the divisor.
            rem_in  = REM_W'(operand >> (ROOT_W - 1));
            data_in = operand << (RAD_W - ROOT_W + 1);
            cnt_in  = CNT_W'(ROOT_W - 1);
         end else begin
            rem_in  = '0;
            data_in = operand;
            cnt_in  = CNT_W'(ROOT_W);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      data_ff <= data_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      dvs_ff  <= dvs_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ortho_shadow_bounds_fit.sv =====
// Top level of the orthographic shadow bounds fit: sequencer, shared multiplier and registers.
// One request at a time; its run time is set by six passes of the shared root/divide unit
// (three roots, three divides) and by the one-bit-per-cycle normalizing shifts.
// An empty box or a light on its target goes from the prepare state straight to done. The response holds until taken.
// Synchronous reset returns the sequencer to idle, zeroes the stored bounds and loads defaults.
`default_nettype none
module ortho_shadow_bounds_fit #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COORD_WIDTH-1:0]     req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0]     req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0]     req_box_min_z,
   input  logic signed [COORD_WIDTH-1:0]     req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0]     req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0]     req_box_max_z,
   input  logic signed [COORD_WIDTH-1:0]     req_light_x,
   input  logic signed [COORD_WIDTH-1:0]     req_light_y,
   input  logic signed [COORD_WIDTH-1:0]     req_light_z,
   input  logic signed [COORD_WIDTH-1:0]     req_aim_x,
   input  logic signed [COORD_WIDTH-1:0]     req_aim_y,
   input  logic signed [COORD_WIDTH-1:0]     req_aim_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [osbf_pkg::OUT_W-1:0]        rsp_half_extent,
   output logic [osbf_pkg::OUT_W-1:0]        rsp_near_dist,
   output logic [osbf_pkg::OUT_W-1:0]        rsp_far_dist,
   output logic                              rsp_changed,
   output logic [1:0]                        rsp_status,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [osbf_pkg::ADDR_W-1:0]       paddr,
   input  logic [osbf_pkg::DATA_W-1:0]       pwdata,
   output logic [osbf_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);
   import osbf_pkg::*;

   localparam int HW  = (COORD_WIDTH + 6 > 36) ? COORD_WIDTH + 6 : 36;
   localparam int CMW = (COORD_WIDTH + 4 > 32) ? COORD_WIDTH + 4 : 32;
   localparam int KW  = $clog2(CMW + 1);
   localparam int VW  = COORD_WIDTH + 1;
   localparam logic [OUT_W-1:0] OUT_MAX = '1;

   logic [OUT_W-1:0]         min_near_ff, min_near_in;
   logic [OUT_W-1:0]         min_radius_ff, min_radius_in;
   logic [TOL_W-1:0]         tol_ff, tol_in;
   logic                     cfg_write;

   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic [1:0]               idx_ff, idx_in;
   logic [KW-1:0]            k_ff, k_in;

   logic signed [COORD_WIDTH-1:0] bmin_ff[3], bmin_in[3];
   logic signed [COORD_WIDTH-1:0] bmax_ff[3], bmax_in[3];
   logic signed [COORD_WIDTH-1:0] lt_ff[3], lt_in[3];
   logic signed [COORD_WIDTH-1:0] aim_ff[3], aim_in[3];
   logic signed [HW-1:0]     t_ff[3], t_in[3];
   logic [CMW-1:0]           c_ff[3], c_in[3];
   logic [VW-1:0]            vm_ff[3], vm_in[3];
   logic [2:0]               vneg_ff, vneg_in;
   logic signed [ROOT_W-1:0] u_ff[3], u_in[3];
   logic [RAD_W-1:0]         acc_ff, acc_in;
   logic [RAD_W-1:0]         prod_ff, prod_in;
   logic [RAD_W-1:0]         lo_ff, lo_in;
   logic [ROOT_W-1:0]        n_ff, n_in;
   logic signed [HW-1:0]     radius_ff, radius_in;
   logic signed [HW-1:0]     along_ff, along_in;
   logic signed [HW-1:0]     across_ff, across_in;
   logic signed [HW-1:0]     nearp_ff, nearp_in;
   logic [OUT_W-1:0]         new_ff[3], new_in[3];
   logic [OUT_W-1:0]         cur_ff[3], cur_in[3];
   logic                     changed_ff, changed_in;
   status_type               status_ff, status_in;

   logic [MUL_W-1:0]         mul_a, mul_b;
   logic [RAD_W-1:0]         mul_p;

   sq_cmd_type               sq_cmd;
   logic [RAD_W-1:0]         sq_operand;
   logic                     sq_done;
   logic [ROOT_W-1:0]        sq_result;

   logic [CMW-1:0]           c_or;
   logic                     c_big, c_small;
   logic signed [HW-1:0]     mu_a;
   logic [HW-1:0]            mu_mag;
   logic signed [ROOT_W-1:0] mu_s;
   logic [ROOT_W-1:0]        mu_smag;
   logic                     mu_neg;
   logic [RAD_W-1:0]         mu_p;
   logic                     mu_rem;
   logic signed [HW-1:0]     mu_res;
   logic signed [HW:0]       am_diff;
   logic [CMW-1:0]           am_mag;
   logic [HW-1:0]            len_val, rad_floor;
   logic signed [HW-1:0]     gap, near_raw, far_raw, far_lim;
   logic [OUT_W-1:0]         tol_base, tol_diff;

   function automatic logic [OUT_W-1:0] to_out(input logic signed [HW-1:0] h);
      logic [HW-1:0] half;
      half = HW'(h >>> 1);
      if (h[HW-1]) return '0;
      if (|(half >> OUT_W)) return OUT_MAX;
      return half[OUT_W-1:0];
   endfunction

   // Configuration port.
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_comb begin
      min_near_in   = min_near_ff;
      min_radius_in = min_radius_ff;
      tol_in        = tol_ff;
      if (cfg_write) begin
         case (paddr[3:2])
            REG_MIN_NEAR:   min_near_in   = pwdata[OUT_W-1:0];
            REG_MIN_RADIUS: min_radius_in = pwdata[OUT_W-1:0];
            REG_CHANGE_TOL: tol_in        = pwdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_MIN_NEAR:   prdata = DATA_W'(min_near_ff);
         REG_MIN_RADIUS: prdata = DATA_W'(min_radius_ff);
         REG_CHANGE_TOL: prdata = DATA_W'(tol_ff);
         default:        prdata = '0;
      endcase
   end

   // Shared multiplier; its product is always registered.
   assign mul_p = RAD_W'(mul_a) * RAD_W'(mul_b);

   osbf_sqdiv u_sqdiv (
      .clock   (clock),
      .reset   (reset),
      .cmd     (sq_cmd),
      .operand (sq_operand),
      .divisor (n_ff),
      .done    (sq_done),
      .result  (sq_result)
   );

   assign c_or    = c_ff[0] | c_ff[1] | c_ff[2];
   assign c_big   = |(c_or >> (ROOT_W - 1));
   assign c_small = ~|(c_or >> (ROOT_W - 2));

   // Product of a wide signed value with a unit component, floored after the 2^30 scale.
   assign mu_a    = (phase_ff == PH_ALONG) ? t_ff[idx_ff] : along_ff;
   assign mu_mag  = mu_a[HW-1] ? HW'(-mu_a) : HW'(mu_a);
   assign mu_s    = u_ff[idx_ff];
   assign mu_smag = mu_s[ROOT_W-1] ? ROOT_W'(-mu_s) : ROOT_W'(mu_s);
   assign mu_neg  = mu_a[HW-1] ^ mu_s[ROOT_W-1];
   assign mu_p    = prod_ff + (lo_ff >> UNIT_SHIFT);
   assign mu_rem  = |lo_ff[UNIT_SHIFT-1:0];
   assign mu_res  = mu_neg ? (HW'(-mu_p) - HW'(mu_rem)) : HW'(mu_p);

   assign am_diff = (HW+1)'(t_ff[idx_ff]) - (HW+1)'(mu_res);
   assign am_mag  = am_diff[HW] ? CMW'(-am_diff) : CMW'(am_diff);

   assign len_val   = HW'(sq_result) << k_ff;
   assign rad_floor = HW'({min_radius_ff, 1'b0});
   assign gap       = HW'({min_near_ff, 1'b0});
   assign near_raw  = along_ff - radius_ff;
   assign far_raw   = along_ff + radius_ff;
   assign far_lim   = nearp_ff + gap;

   assign tol_base = (new_ff[idx_ff] > UNIT_ONE) ? new_ff[idx_ff] : UNIT_ONE;
   assign tol_diff = (cur_ff[idx_ff] > new_ff[idx_ff]) ? (cur_ff[idx_ff] - new_ff[idx_ff])
                                                       : (new_ff[idx_ff] - cur_ff[idx_ff]);

   always_comb begin
      logic signed [VW-1:0] dv;
      logic signed [VW-1:0] vd;
      logic                 empty;
      logic                 on_target;

      dv         = '0;
      vd         = '0;
      empty      = 1'b0;
      on_target  = 1'b0;
      state_in   = state_ff;
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      k_in       = k_ff;
      bmin_in    = bmin_ff;
      bmax_in    = bmax_ff;
      lt_in      = lt_ff;
      aim_in     = aim_ff;
      t_in       = t_ff;
      c_in       = c_ff;
      vm_in      = vm_ff;
      vneg_in    = vneg_ff;
      u_in       = u_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      lo_in      = lo_ff;
      n_in       = n_ff;
      radius_in  = radius_ff;
      along_in   = along_ff;
      across_in  = across_ff;
      nearp_in   = nearp_ff;
      new_in     = new_ff;
      cur_in     = cur_ff;
      changed_in = changed_ff;
      status_in  = status_ff;
      mul_a      = '0;
      mul_b      = '0;
      sq_cmd     = '0;
      sq_operand = acc_ff + prod_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bmin_in[0] = req_box_min_x;
               bmin_in[1] = req_box_min_y;
               bmin_in[2] = req_box_min_z;
               bmax_in[0] = req_box_max_x;
               bmax_in[1] = req_box_max_y;
               bmax_in[2] = req_box_max_z;
               lt_in[0]   = req_light_x;
               lt_in[1]   = req_light_y;
               lt_in[2]   = req_light_z;
               aim_in[0]  = req_aim_x;
               aim_in[1]  = req_aim_y;
               aim_in[2]  = req_aim_z;
               state_in   = ST_PREP;
            end
         end
         ST_PREP: begin
            changed_in = 1'b0;
            empty      = (bmin_ff[0] > bmax_ff[0]) || (bmin_ff[1] > bmax_ff[1]) ||
                         (bmin_ff[2] > bmax_ff[2]);
            on_target  = (aim_ff[0] == lt_ff[0]) && (aim_ff[1] == lt_ff[1]) &&
                         (aim_ff[2] == lt_ff[2]);
            for (int i = 0; i < 3; i++) begin
               // Offset to the box centre is kept in half-LSB units.
               t_in[i]    = HW'(bmin_ff[i]) + HW'(bmax_ff[i]) - (HW'(lt_ff[i]) <<< 1);
               dv         = VW'(bmax_ff[i]) - VW'(bmin_ff[i]);
               c_in[i]    = CMW'(dv);
               vd         = VW'(aim_ff[i]) - VW'(lt_ff[i]);
               vneg_in[i] = vd[VW-1];
               vm_in[i]   = vd[VW-1] ? VW'(-vd) : VW'(vd);
            end
            if (empty) begin
               status_in = STATUS_EMPTY;
               state_in  = ST_DONE;
            end else if (on_target) begin
               status_in = STATUS_ON_TARGET;
               state_in  = ST_DONE;
            end else begin
               status_in = STATUS_OK;
               phase_in  = PH_RADIUS;
               k_in      = '0;
               state_in  = ST_NORM;
            end
         end
         ST_NORM: begin
            if (c_big) begin
               for (int i = 0; i < 3; i++) c_in[i] = c_ff[i] >> 1;
               k_in = k_ff + 1'b1;
            end else if ((phase_ff == PH_DIR) && c_small) begin
               for (int i = 0; i < 3; i++) c_in[i] = c_ff[i] << 1;
            end else begin
               acc_in   = '0;
               idx_in   = '0;
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            mul_a    = c_ff[idx_ff][MUL_W-1:0];
            mul_b    = c_ff[idx_ff][MUL_W-1:0];
            prod_in  = mul_p;
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            acc_in = acc_ff + prod_ff;
            if (idx_ff == 2'd2) begin
               sq_cmd.start  = 1'b1;
               sq_cmd.is_div = 1'b0;
               state_in      = ST_ROOT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_ROOT: begin
            if (sq_done) begin
               case (phase_ff)
                  PH_RADIUS: begin
                     radius_in = (len_val < rad_floor) ? rad_floor : len_val;
                     for (int i = 0; i < 3; i++) c_in[i] = CMW'(vm_ff[i]);
                     k_in     = '0;
                     phase_in = PH_DIR;
                     state_in = ST_NORM;
                  end
                  PH_DIR: begin
                     n_in     = sq_result;
                     idx_in   = '0;
                     state_in = ST_DIV_GO;
                  end
                  default: begin
                     across_in = len_val;
                     state_in  = ST_NEAR;
                  end
               endcase
            end
         end
         ST_DIV_GO: begin
            sq_cmd.start  = 1'b1;
            sq_cmd.is_div = 1'b1;
            sq_operand    = RAD_W'(c_ff[idx_ff][ROOT_W-2:0]) << UNIT_SHIFT;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (sq_done) begin
               u_in[idx_ff] = vneg_ff[idx_ff] ? -ROOT_W'(sq_result) : ROOT_W'(sq_result);
               if (idx_ff == 2'd2) begin
                  idx_in   = '0;
                  along_in = '0;
                  phase_in = PH_ALONG;
                  state_in = ST_MU_LO;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_MU_LO: begin
            mul_a    = MUL_W'(mu_mag[UNIT_SHIFT-1:0]);
            mul_b    = mu_smag;
            prod_in  = mul_p;
            state_in = ST_MU_HI;
         end
         ST_MU_HI: begin
            lo_in    = prod_ff;
            mul_a    = MUL_W'(mu_mag >> UNIT_SHIFT);
            mul_b    = mu_smag;
            prod_in  = mul_p;
            state_in = ST_MU_FIN;
         end
         ST_MU_FIN: begin
            if (phase_ff == PH_ALONG) begin
               along_in = along_ff + mu_res;
               if (idx_ff == 2'd2) begin
                  idx_in   = '0;
                  phase_in = PH_AM;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
               state_in = ST_MU_LO;
            end else begin
               c_in[idx_ff] = am_mag;
               if (idx_ff == 2'd2) begin
                  phase_in = PH_ACROSS;
                  k_in     = '0;
                  state_in = ST_NORM;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_MU_LO;
               end
            end
         end
         ST_NEAR: begin
            new_in[0] = to_out(across_ff + radius_ff);
            nearp_in  = (near_raw < gap) ? gap : near_raw;
            state_in  = ST_FAR;
         end
         ST_FAR: begin
            new_in[1] = to_out(nearp_ff);
            new_in[2] = to_out((far_raw < far_lim) ? far_lim : far_raw);
            idx_in    = '0;
            state_in  = ST_TOL_MUL;
         end
         ST_TOL_MUL: begin
            mul_a    = MUL_W'(tol_ff);
            mul_b    = MUL_W'(tol_base);
            prod_in  = mul_p;
            state_in = ST_TOL_CMP;
         end
         ST_TOL_CMP: begin
            // A stored value moves only when the change beats the relative tolerance.
            if ({1'b0, tol_diff, {TOL_SHIFT{1'b0}}} > prod_ff[CMP_W-1:0]) begin
               cur_in[idx_ff] = new_ff[idx_ff];
               changed_in     = 1'b1;
            end
            if (idx_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_TOL_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_near_ff   <= MIN_NEAR_RESET;
         min_radius_ff <= MIN_RADIUS_RESET;
         tol_ff        <= TOL_RESET;
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_RADIUS;
         cur_ff        <= '{default: '0};
         changed_ff    <= 1'b0;
         status_ff     <= STATUS_OK;
      end else begin
         min_near_ff   <= min_near_in;
         min_radius_ff <= min_radius_in;
         tol_ff        <= tol_in;
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         cur_ff        <= cur_in;
         changed_ff    <= changed_in;
         status_ff     <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      k_ff      <= k_in;
      bmin_ff   <= bmin_in;
      bmax_ff   <= bmax_in;
      lt_ff     <= lt_in;
      aim_ff    <= aim_in;
      t_ff      <= t_in;
      c_ff      <= c_in;
      vm_ff     <= vm_in;
      vneg_ff   <= vneg_in;
      u_ff      <= u_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      lo_ff     <= lo_in;
      n_ff      <= n_in;
      radius_ff <= radius_in;
      along_ff  <= along_in;
      across_ff <= across_in;
      nearp_ff  <= nearp_in;
      new_ff    <= new_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_half_extent = cur_ff[0];
   assign rsp_near_dist   = cur_ff[1];
   assign rsp_far_dist    = cur_ff[2];
   assign rsp_changed     = changed_ff;
   assign rsp_status      = status_ff;

endmodule
`default_nettype wire

// ===== rtl/core/osbf_check.sv =====
// Port-level assertions for the shadow bounds fit, bound to the top level.
`default_nettype none
module osbf_check #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [osbf_pkg::OUT_W-1:0]    rsp_half_extent,
   input  logic [osbf_pkg::OUT_W-1:0]    rsp_near_dist,
   input  logic [osbf_pkg::OUT_W-1:0]    rsp_far_dist,
   input  logic                          rsp_changed,
   input  logic [1:0]                    rsp_status,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_x
);
   import osbf_pkg::*;

   // A held response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_half_extent) &&
         $stable(rsp_near_dist) && $stable(rsp_far_dist) && $stable(rsp_changed) &&
         $stable(rsp_status))
      else $error("response changed while stalled");

   // No new request is taken while a response is pending.
   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request channel open with a response pending");

   // An accepted request never produces a response in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("block not busy after accepting a request");

   // Error status never reports a change of the stored bounds.
   a_status_nochange: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> !rsp_changed)
      else $error("changed flag set with error status");

   // A stalled request stays offered; of its payload only the box minimum x is checked.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_box_min_x))
      else $error("request changed while stalled");

endmodule

bind ortho_shadow_bounds_fit osbf_check #(.COORD_WIDTH(COORD_WIDTH)) u_osbf_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_half_extent (rsp_half_extent),
   .rsp_near_dist   (rsp_near_dist),
   .rsp_far_dist    (rsp_far_dist),
   .rsp_changed     (rsp_changed),
   .rsp_status      (rsp_status),
   .req_box_min_x   (req_box_min_x)
);
`default_nettype wire
